FILE: src/kscs_pkg.sv
// shared constants, codes and types for the k-segment common substring block
`default_nettype none
package kscs_pkg;

  localparam int unsigned MaxLen      = 128;
  localparam int unsigned MaxSegments = 10;

  localparam int unsigned ActW     = 2;
  localparam int unsigned SymW     = 8;
  localparam int unsigned PosW     = 8;
  localparam int unsigned ValW     = 8;
  localparam int unsigned SLenW    = 8;
  localparam int unsigned SegW     = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [ActW-1:0] ACT_LOAD_S = 2'd0;
  localparam logic [ActW-1:0] ACT_LOAD_T = 2'd1;
  localparam logic [ActW-1:0] ACT_START  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_S_LENGTH      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_T_LENGTH      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SEGMENT_COUNT = 2'd2;

  // row token travelling down the chain
  typedef struct packed {
    logic            valid;
    logic            last;
    logic [SymW-1:0] sym;
    logic [ValW-1:0] run;
  } tok_t;

endpackage
`default_nettype wire

FILE: src/kscs_in_if.sv
// request channel carrying load and start items
`default_nettype none
interface kscs_in_if;
  import kscs_pkg::*;
  logic            valid;
  logic            ready;
  logic [ActW-1:0] action;
  logic [SymW-1:0] symbol;
  logic [PosW-1:0] position;
  modport source (output valid, output action, output symbol, output position, input ready);
  modport sink (input valid, input action, input symbol, input position, output ready);
endinterface
`default_nettype wire

FILE: src/kscs_out_if.sv
// result channel carrying the total length
`default_nettype none
interface kscs_out_if;
  import kscs_pkg::*;
  logic            valid;
  logic            ready;
  logic [ValW-1:0] total_length;
  modport source (output valid, output total_length, input ready);
  modport sink (input valid, input total_length, output ready);
endinterface
`default_nettype wire

FILE: src/k_segment_common_substring_dp.sv
// top level: string store, row feeder, column cell chain and result pick
// flow: a load is stored on acceptance; a start clears the cells, feeds n rows of s, waits
//   until the last row leaves cell m, then picks; a zero size goes straight to output
// throughput: one item at a time; loads back to back at one per cycle while idle; the next
//   request is taken the cycle after the result leaves
// reset: control idle, lengths and count to 1; dp cleared at each start with nonzero sizes
`default_nettype none
module k_segment_common_substring_dp #(
  parameter int unsigned MAX_LEN      = kscs_pkg::MaxLen,
  parameter int unsigned MAX_SEGMENTS = kscs_pkg::MaxSegments
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [kscs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [kscs_pkg::CfgDataW-1:0]  cfg_data_i,
  kscs_in_if.sink                             in_i,
  kscs_out_if.source                          out_o
);
  import kscs_pkg::*;

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned SW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned KW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CLEAR = 6'b000010,
    ST_FEED  = 6'b000100,
    ST_WAIT  = 6'b001000,
    ST_PICK  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  state_e state_q;
  logic [SLenW-1:0] s_len_q, t_len_q;
  logic [SegW-1:0]  seg_q;
  logic [LW-1:0]    n_q, m_q, cnt_q, n_c, m_c;
  logic [SW-1:0]    k_q, k_c;
  logic [SymW-1:0]  s_mem [MAX_LEN];
  logic [SymW-1:0]  s_rd_q;
  logic             feed_valid_q, feed_last_q;
  logic [MAX_SEGMENTS-1:0][ValW-1:0] vec_q;
  logic [ValW-1:0]  res_q;
  logic             acc, pos_ok;

  tok_t                              c_tok  [MAX_LEN+1];
  logic [MAX_SEGMENTS-1:0][ValW-1:0] c_best [MAX_LEN+1];
  logic [MAX_SEGMENTS-1:0][ValW-1:0] c_anch [MAX_LEN+1];

  assign in_i.ready   = state_q == ST_IDLE;
  assign acc          = in_i.valid && in_i.ready;
  assign pos_ok       = (in_i.position != '0) && (32'(in_i.position) <= 32'(MAX_LEN));
  assign out_o.valid  = state_q == ST_OUT;
  assign out_o.total_length = res_q;

  always_comb begin
    n_c = (32'(s_len_q) > 32'(MAX_LEN)) ? LW'(MAX_LEN) : LW'(s_len_q);
    m_c = (32'(t_len_q) > 32'(MAX_LEN)) ? LW'(MAX_LEN) : LW'(t_len_q);
    k_c = (32'(seg_q) > 32'(MAX_SEGMENTS)) ? SW'(MAX_SEGMENTS) : SW'(seg_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_len_q <= SLenW'(1);
      t_len_q <= SLenW'(1);
      seg_q   <= SegW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_S_LENGTH:      s_len_q <= cfg_data_i;
        CFG_T_LENGTH:      t_len_q <= cfg_data_i;
        CFG_SEGMENT_COUNT: seg_q   <= cfg_data_i[SegW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && in_i.action == ACT_LOAD_S && pos_ok) begin
      s_mem[AW'(in_i.position - PosW'(1))] <= in_i.symbol;
    end
    s_rd_q <= s_mem[cnt_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      feed_valid_q <= 1'b0;
      feed_last_q  <= 1'b0;
    end else begin
      feed_valid_q <= state_q == ST_FEED;
      feed_last_q  <= (state_q == ST_FEED) && (cnt_q == n_q - LW'(1));
      case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (acc && in_i.action == ACT_START) begin
            if (n_c == '0 || m_c == '0 || k_c == '0) begin
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_CLEAR;
            end
          end
        end
        ST_CLEAR: state_q <= ST_FEED;
        ST_FEED: begin
          cnt_q <= cnt_q + LW'(1);
          if (cnt_q == n_q - LW'(1)) begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (c_tok[m_q].valid && c_tok[m_q].last) begin
            state_q <= ST_PICK;
          end
        end
        ST_PICK: state_q <= ST_OUT;
        ST_OUT: begin
          if (out_o.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && acc && in_i.action == ACT_START) begin
      n_q   <= n_c;
      m_q   <= m_c;
      k_q   <= k_c;
      res_q <= '0;
    end
    if (state_q == ST_WAIT) begin
      vec_q <= c_best[m_q];
    end
    if (state_q == ST_PICK) begin
      res_q <= vec_q[KW'(k_q - SW'(1))];
    end
  end

  // column zero: row tokens with all-zero neighbors
  assign c_tok[0]  = '{valid: feed_valid_q, last: feed_last_q, sym: s_rd_q, run: '0};
  assign c_best[0] = '0;
  assign c_anch[0] = '0;

  for (genvar g = 0; g < int'(MAX_LEN); g++) begin : g_col
    kscs_cell #(
      .J  (g + 1),
      .MS (MAX_SEGMENTS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .clear_i  (state_q == ST_CLEAR),
      .ld_i     (acc && in_i.action == ACT_LOAD_T),
      .ld_pos_i (in_i.position),
      .ld_sym_i (in_i.symbol),
      .tok_i    (c_tok[g]),
      .best_i   (c_best[g]),
      .anch_i   (c_anch[g]),
      .tok_o    (c_tok[g+1]),
      .best_o   (c_best[g+1]),
      .anch_o   (c_anch[g+1])
    );
  end

endmodule
`default_nettype wire

FILE: src/kscs_cell.sv
// one column cell of the systolic dp chain, all segment layers in parallel
`default_nettype none
module kscs_cell #(
  parameter int unsigned J  = 1,
  parameter int unsigned MS = kscs_pkg::MaxSegments
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          clear_i,
  input  wire logic                          ld_i,
  input  wire logic [kscs_pkg::PosW-1:0]     ld_pos_i,
  input  wire logic [kscs_pkg::SymW-1:0]     ld_sym_i,
  input  wire kscs_pkg::tok_t                tok_i,
  input  wire logic [MS-1:0][kscs_pkg::ValW-1:0] best_i,
  input  wire logic [MS-1:0][kscs_pkg::ValW-1:0] anch_i,
  output kscs_pkg::tok_t                     tok_o,
  output logic [MS-1:0][kscs_pkg::ValW-1:0]  best_o,
  output logic [MS-1:0][kscs_pkg::ValW-1:0]  anch_o
);
  import kscs_pkg::*;

  logic [SymW-1:0]           t_sym_q;
  logic [ValW-1:0]           diag_run_q;
  logic [MS-1:0][ValW-1:0]   diag_best_q, diag_anch_q;
  logic                      tok_valid_q, tok_last_q;
  logic [SymW-1:0]           tok_sym_q;
  logic [ValW-1:0]           tok_run_q, run_d;
  logic [MS-1:0][ValW-1:0]   best_q, best_d, anch_d;
  logic                      match;
  logic [ValW-1:0]           r, prev, take, v;

  always_ff @(posedge clk_i) begin
    if (ld_i && (32'(ld_pos_i) == 32'(J))) begin
      t_sym_q <= ld_sym_i;
    end
  end

  always_comb begin
    match  = tok_i.sym == t_sym_q;
    r      = diag_run_q + ValW'(1);
    // a run keeps the anchor of the cell just before it started
    anch_d = (diag_run_q != '0) ? diag_anch_q : diag_best_q;
    best_d = best_q;
    for (int p = 0; p < int'(MS); p++) begin
      prev = (p == 0) ? '0 : anch_d[p-1];
      take = r + prev;
      v    = (best_i[p] > best_q[p]) ? best_i[p] : best_q[p];
      if (match && take > v) begin
        v = take;
      end
      best_d[p] = v;
    end
    run_d = match ? r : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
      tok_last_q  <= 1'b0;
    end else if (clear_i) begin
      tok_valid_q <= 1'b0;
      tok_last_q  <= 1'b0;
    end else begin
      tok_valid_q <= tok_i.valid;
      tok_last_q  <= tok_i.valid && tok_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear_i) begin
      diag_run_q  <= '0;
      diag_best_q <= '0;
      diag_anch_q <= '0;
      best_q      <= '0;
      tok_run_q   <= '0;
      anch_o      <= '0;
    end else begin
      diag_run_q  <= tok_i.run;
      diag_best_q <= best_i;
      diag_anch_q <= anch_i;
      if (tok_i.valid) begin
        best_q    <= best_d;
        tok_run_q <= run_d;
        tok_sym_q <= tok_i.sym;
        anch_o    <= anch_d;
      end
    end
  end

  assign tok_o  = '{valid: tok_valid_q, last: tok_last_q, sym: tok_sym_q, run: tok_run_q};
  assign best_o = best_q;

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// self-checking testbench for the k-segment common substring block
`default_nettype none
module testbench;
  import kscs_pkg::*;

  localparam logic [ActW-1:0] ActUnused = 2'd3;
  localparam int unsigned CycleLimit = 1_500_000;
  localparam int unsigned SettleCycles = 2 * MaxLen + 40;

  typedef struct {
    logic [ActW-1:0] act;
    logic [SymW-1:0] sym;
    logic [PosW-1:0] pos;
    int              want;  // -1: take the value from the predictor
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  kscs_in_if  req_if ();
  kscs_out_if res_if ();

  k_segment_common_substring_dp dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (req_if.sink),
    .out_o     (res_if.source)
  );

  // predictor state
  logic [SymW-1:0]  s_sym [1:MaxLen];
  logic [SymW-1:0]  t_sym [1:MaxLen];
  bit               s_set [1:MaxLen];
  bit               t_set [1:MaxLen];
  logic [SLenW-1:0] s_len_q;
  logic [SLenW-1:0] t_len_q;
  logic [SegW-1:0]  seg_q;
  int               run_len [0:MaxLen][0:MaxLen];
  int               best_len [0:MaxLen][0:MaxLen][0:MaxSegments];

  logic [ValW-1:0] pending_len [$];
  int  errors;
  int  items_sent;
  int  results_seen;
  int  phases;
  int  cycles;
  bit  no_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout at %0t", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int clip_to(int v, int top);
    return v > top ? top : v;
  endfunction

  function automatic logic [ValW-1:0] segments_total();
    int n, m, k, r, v, take;
    n = clip_to(int'(s_len_q), int'(MaxLen));
    m = clip_to(int'(t_len_q), int'(MaxLen));
    k = clip_to(int'(seg_q), int'(MaxSegments));
    for (int i = 0; i <= n; i++)
      for (int j = 0; j <= m; j++) begin
        run_len[i][j] = 0;
        for (int p = 0; p <= MaxSegments; p++) best_len[i][j][p] = 0;
      end
    for (int i = 1; i <= n; i++)
      for (int j = 1; j <= m; j++)
        if (s_sym[i] == t_sym[j]) run_len[i][j] = 1 + run_len[i-1][j-1];
    for (int i = 1; i <= n; i++)
      for (int j = 1; j <= m; j++) begin
        r = run_len[i][j];
        for (int p = 1; p <= k; p++) begin
          v = best_len[i-1][j][p] > best_len[i][j-1][p] ?
              best_len[i-1][j][p] : best_len[i][j-1][p];
          if (s_sym[i] == t_sym[j]) begin
            take = r + best_len[i-r][j-r][p-1];
            if (take > v) v = take;
          end
          best_len[i][j][p] = v;
        end
      end
    return best_len[n][m][k][ValW-1:0];
  endfunction

  // advance the model by one accepted request
  task automatic absorb(logic [ActW-1:0] act, logic [SymW-1:0] sym, logic [PosW-1:0] pos,
                        int want);
    logic [ValW-1:0] val;
    if (act == ACT_LOAD_S || act == ACT_LOAD_T) begin
      if (pos >= 1 && pos <= MaxLen) begin
        if (act == ACT_LOAD_S) begin
          s_sym[pos] = sym;
          s_set[pos] = 1'b1;
        end else begin
          t_sym[pos] = sym;
          t_set[pos] = 1'b1;
        end
      end
    end else if (act == ACT_START) begin
      val = segments_total();
      if (want >= 0) val = want[ValW-1:0];
      pending_len.push_back(val);
    end
  endtask

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(logic [ActW-1:0] act, logic [SymW-1:0] sym, logic [PosW-1:0] pos,
                      int want);
    int gap;
    req_if.valid    <= 1'b1;
    req_if.action   <= act;
    req_if.symbol   <= sym;
    req_if.position <= pos;
    do @(posedge clk_i); while (!req_if.ready);
    absorb(act, sym, pos, want);
    items_sent++;
    gap = gap_len();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_len.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == CFG_S_LENGTH) s_len_q = data;
    else if (idx == CFG_T_LENGTH) t_len_q = data;
    else if (idx == CFG_SEGMENT_COUNT) seg_q = data[SegW-1:0];
  endtask

  // random receiver stalls
  int stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (no_idle || $urandom_range(0, 99) < 70) begin
      res_if.ready <= 1'b1;
    end else begin
      res_if.ready <= 1'b0;
      stall_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                  : $urandom_range(0, 2);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen++;
      if (pending_len.size() == 0) begin
        $display("%0t: unexpected result total_length=%0d", $time, res_if.total_length);
        errors++;
      end else begin
        if (res_if.total_length !== pending_len[0]) begin
          $display("%0t: total_length expected %0d actual %0d", $time, pending_len[0],
                   res_if.total_length);
          errors++;
        end
        void'(pending_len.pop_front());
      end
    end
  end

  row_t directed [] = '{
    '{ACT_START,  8'h00, 8'd0,   0},    // after reset, strings unread? lengths 1 -> loaded below
    '{ACT_LOAD_S, 8'hff, 8'd1,   -1},
    '{ACT_LOAD_T, 8'hff, 8'd1,   -1},
    '{ACT_START,  8'h5a, 8'd77,  1},
    '{ACT_LOAD_T, 8'h00, 8'd1,   -1},
    '{ACT_START,  8'h00, 8'd0,   0},
    '{ActUnused,  8'hff, 8'd1,   -1},   // unused action is ignored
    '{ACT_LOAD_T, 8'hff, 8'd0,   -1},   // position zero ignored
    '{ACT_LOAD_T, 8'hff, 8'd129, -1},   // beyond the string ignored
    '{ACT_LOAD_S, 8'h00, 8'd255, -1},
    '{ACT_START,  8'hff, 8'd255, 0},
    '{ACT_LOAD_S, 8'h00, 8'd1,   -1},
    '{ACT_START,  8'h00, 8'd1,   1},
    '{ACT_LOAD_S, 8'h80, 8'd128, -1},
    '{ACT_LOAD_T, 8'h7f, 8'd128, -1},
    '{ACT_START,  8'h00, 8'd0,   -1}
  };

  // length and segment settings visited first: zeros, saturation, extremes
  int cfg_plan [][3] = '{
    '{0, 5, 3}, '{6, 0, 2}, '{4, 4, 0}, '{255, 200, 15},
    '{128, 128, 10}, '{1, 128, 1}, '{128, 1, 10}, '{3, 7, 11}
  };

  initial begin
    int sl, tl, sg, cnt, roll, width;
    logic [SymW-1:0] sym;
    errors = 0; items_sent = 0; results_seen = 0; phases = 0; cycles = 0;
    no_idle = 1'b0;
    s_len_q = 1; t_len_q = 1; seg_q = 1;
    for (int i = 1; i <= MaxLen; i++) begin
      s_sym[i] = '0; t_sym[i] = '0; s_set[i] = 1'b0; t_set[i] = 1'b0;
    end
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = CFG_S_LENGTH; cfg_data_i = '0;
    req_if.valid = 1'b0; req_if.action = ACT_LOAD_S;
    req_if.symbol = '0; req_if.position = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first row would need position 1 written first, so it is skipped
    for (int r = 1; r < directed.size(); r++)
      send(directed[r].act, directed[r].sym, directed[r].pos, directed[r].want);

    while (items_sent < 950) begin
      drain();
      phases++;
      if (phases <= cfg_plan.size()) begin
        sl = cfg_plan[phases-1][0]; tl = cfg_plan[phases-1][1]; sg = cfg_plan[phases-1][2];
      end else begin
        sl = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 255) : $urandom_range(1, 12);
        tl = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 255) : $urandom_range(1, 12);
        sg = $urandom_range(0, 15);
      end
      write_reg(CFG_S_LENGTH, sl[CfgDataW-1:0]);
      write_reg(CFG_T_LENGTH, tl[CfgDataW-1:0]);
      write_reg(CFG_SEGMENT_COUNT, sg[CfgDataW-1:0]);
      cfg_we_i <= 1'b0;
      no_idle = ($urandom_range(0, 5) == 0);
      width = $urandom_range(1, 3);
      sl = clip_to(int'(s_len_q), int'(MaxLen));
      tl = clip_to(int'(t_len_q), int'(MaxLen));
      // every symbol a start will read must exist
      for (int p = 1; p <= sl; p++)
        if (!s_set[p]) send(ACT_LOAD_S, SymW'($urandom_range(0, width)), PosW'(p), -1);
      for (int p = 1; p <= tl; p++)
        if (!t_set[p]) send(ACT_LOAD_T, SymW'($urandom_range(0, width)), PosW'(p), -1);
      cnt = (sl > 40 || tl > 40) ? 12 : $urandom_range(15, 50);
      for (int n = 0; n < cnt; n++) begin
        roll = $urandom_range(0, 99);
        sym = ($urandom_range(0, 9) == 0) ? SymW'($urandom) : SymW'($urandom_range(0, width));
        if (roll < 15)
          send(ACT_START, SymW'($urandom), PosW'($urandom), -1);
        else if (roll < 20)
          send(ActUnused, SymW'($urandom), PosW'($urandom), -1);
        else if (roll < 24)
          send(roll[0] ? ACT_LOAD_S : ACT_LOAD_T, sym,
               PosW'($urandom_range(0, 1) ? 0 : $urandom_range(129, 255)), -1);
        else if (roll < 62)
          send(ACT_LOAD_S, sym, PosW'($urandom_range(1, sl > 0 ? sl : 1)), -1);
        else
          send(ACT_LOAD_T, sym, PosW'($urandom_range(1, tl > 0 ? tl : 1)), -1);
      end
      send(ACT_START, SymW'($urandom), PosW'($urandom), -1);
    end
    drain();

    $display("%0d requests over %0d length/segment settings, %0d results checked",
             items_sent, phases, results_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
